FILE: design/ida_pkg.sv
// ida_pkg: shared constants, types and helpers for the id bitmap allocator
// no dependencies; imported by every module of the block

package ida_pkg;

    localparam int NUM_IDS   = 1024;
    localparam int WORD_BITS = 32;
    localparam int NWORDS    = NUM_IDS / WORD_BITS;
    localparam int ID_W      = 10;
    localparam int WADDR_W   = $clog2(NWORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [BIT_W-1:0]     bidx_t;
    typedef logic [ID_W-1:0]      id_t;

    // find-first-zero result
    typedef struct packed {
        logic  found;
        bidx_t idx;
    } ffz_t;

    // value of a bitmap word that was never written since reset: only id 0 is used
    function automatic word_t word_reset_value(input waddr_t addr);
        word_t v;
        v = '0;
        if (addr == '0)
        begin
            v = word_t'(1);
        end
        return v;
    endfunction

endpackage

FILE: design/ida_bitmap.sv
// ida_bitmap: used-bit bitmap storage, one write and one registered read port
// per-word valid bits make unwritten words read as their reset value; uses ida_pkg

module ida_bitmap (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  ida_pkg::waddr_t rd_addr,
    output ida_pkg::word_t  rd_data,
    input  logic            wr_en,
    input  ida_pkg::waddr_t wr_addr,
    input  ida_pkg::word_t  wr_data
);
    import ida_pkg::*;

    word_t               mem_reg [NWORDS];
    logic [NWORDS-1:0]   valid_reg;
    word_t               raw_reg;
    logic                raw_valid_reg;
    waddr_t              raddr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            raw_reg   <= mem_reg[rd_addr];
            raddr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            raw_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                raw_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = raw_valid_reg ? raw_reg : word_reset_value(raddr_reg);

endmodule

FILE: design/ida_ffz.sv
// ida_ffz: find-first-zero unit, shared by every step of the word scan
// pure combinational priority encoder; uses ida_pkg

module ida_ffz (
    input  ida_pkg::word_t word_in,
    output ida_pkg::ffz_t  result
);
    import ida_pkg::*;

    always_comb
    begin
        result = '0;
        // walk down so the lowest clear bit wins
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word_in[i])
            begin
                result.found = 1'b1;
                result.idx   = bidx_t'(i);
            end
        end
    end

endmodule

FILE: design/id_bitmap_allocator.sv
// id_bitmap_allocator: next-fit id allocator, top level with the scan sequencer
// instantiates ida_bitmap and ida_ffz; uses ida_pkg

// One input word is either an allocate or a release request, and each request
// gives exactly one result word. A release reads the bitmap word in the accept
// cycle and then, in the S_REL state, writes it back with the bit cleared and
// registers its result word, waiting there while the output register is full.
// An allocate reads one bitmap word per cycle through the single read port,
// starting at the word that holds the id after the last released one and
// wrapping around. It stops at the first word with a free bit or after a full
// sweep of all NWORDS words, and registers its result word once the output
// register is free; a sweep of the ring without a free bit returns status 1
// and id 0. The block takes one request at a time: in_ready is high only while
// no request is in work, but a finished result may still wait in the output
// register, and a request that finishes while that word is still held waits in
// place until out_ready frees it. Right after reset only id 0 is marked used,
// and the block is ready at once, with no clearing pass.

module id_bitmap_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          action,
    input  ida_pkg::id_t  id_in,
    output logic          out_valid,
    input  logic          out_ready,
    output ida_pkg::id_t  id_out,
    output logic          status
);
    import ida_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_REL  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0] state_reg, state_next;
    waddr_t     waddr_reg, waddr_next;
    waddr_t     count_reg, count_next;
    id_t        rel_id_reg, rel_id_next;
    id_t        last_rel_reg, last_rel_next;
    logic       out_valid_reg, out_valid_next;
    id_t        id_out_reg, id_out_next;
    logic       status_reg, status_next;

    logic       rd_en;
    waddr_t     rd_addr;
    word_t      rd_data;
    logic       wr_en;
    word_t      wr_data;
    ffz_t       ffz;

    logic              out_free;
    logic [ID_W:0]     start_full;
    id_t               start_id;
    logic              rel_in_range;
    waddr_t            waddr_inc;

    ida_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (waddr_reg),
        .wr_data (wr_data)
    );

    ida_ffz u_ffz (
        .word_in (rd_data),
        .result  (ffz)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign id_out    = id_out_reg;
    assign status    = status_reg;

    assign out_free = !out_valid_reg || out_ready;

    // next-fit start point wraps to 0 past the top id
    assign start_full   = {1'b0, last_rel_reg} + (ID_W+1)'(1);
    assign start_id     = (start_full >= (ID_W+1)'(NUM_IDS)) ? '0 : start_full[ID_W-1:0];
    assign rel_in_range = ({1'b0, rel_id_reg} < (ID_W+1)'(NUM_IDS));
    assign waddr_inc    = (waddr_reg == waddr_t'(NWORDS - 1)) ? '0 : waddr_reg + waddr_t'(1);

    always_comb
    begin
        state_next     = state_reg;
        waddr_next     = waddr_reg;
        count_next     = count_reg;
        rel_id_next    = rel_id_reg;
        last_rel_next  = last_rel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        id_out_next    = id_out_reg;
        status_next    = status_reg;
        rd_en          = 1'b0;
        rd_addr        = waddr_reg;
        wr_en          = 1'b0;
        wr_data        = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rd_en = 1'b1;
                    if (action == ACT_RELEASE)
                    begin
                        rd_addr     = waddr_t'(id_in >> BIT_W);
                        rel_id_next = id_in;
                        state_next  = S_REL;
                    end
                    else
                    begin
                        rd_addr    = waddr_t'(start_id >> BIT_W);
                        count_next = '0;
                        state_next = S_SCAN;
                    end
                    waddr_next = rd_addr;
                end
            end
            S_REL:
            begin
                if (out_free)
                begin
                    if (rel_in_range)
                    begin
                        wr_en         = 1'b1;
                        wr_data       = rd_data & ~(word_t'(1) << bidx_t'(rel_id_reg));
                        last_rel_next = rel_id_reg;
                    end
                    out_valid_next = 1'b1;
                    id_out_next    = rel_id_reg;
                    status_next    = STATUS_OK;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (ffz.found)
                begin
                    if (out_free)
                    begin
                        wr_en          = 1'b1;
                        wr_data        = rd_data | (word_t'(1) << ffz.idx);
                        out_valid_next = 1'b1;
                        id_out_next    = id_t'({waddr_reg, ffz.idx});
                        status_next    = STATUS_OK;
                        state_next     = S_IDLE;
                    end
                end
                else if (count_reg == waddr_t'(NWORDS - 1))
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        id_out_next    = '0;
                        status_next    = STATUS_FAIL;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    // word full: fetch the next one around the ring
                    rd_en      = 1'b1;
                    rd_addr    = waddr_inc;
                    waddr_next = waddr_inc;
                    count_next = count_reg + waddr_t'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_rel_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_rel_reg  <= last_rel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg  <= waddr_next;
        count_reg  <= count_next;
        rel_id_reg <= rel_id_next;
        id_out_reg <= id_out_next;
        status_reg <= status_next;
    end

endmodule

FILE: design/ida_checker.sv
// ida_checker: port-level assertions for id_bitmap_allocator, bound to the top
// sees only the top-level ports; uses ida_pkg

module ida_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         action,
    input ida_pkg::id_t id_in,
    input logic         out_valid,
    input logic         out_ready,
    input ida_pkg::id_t id_out,
    input logic         status
);
    import ida_pkg::*;

    // the block is not ready in the cycle after it takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("block ready right after taking a request");

    // a new result only appears while a request was in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result word without a request in work");

    // a failed allocation reports id 0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FAIL) |-> (id_out == '0))
    else $error("failed allocation with nonzero id");

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(id_out) && $stable(status))
    else $error("result word changed while stalled");

endmodule

bind id_bitmap_allocator ida_checker u_ida_checker (.*);

FILE: tb/sv/tb_id_bitmap_allocator.sv
// tb_id_bitmap_allocator: self-checking bench for the next-fit id allocator
// directed table, partial bitmap fill, then mixed random traffic; uses ida_pkg and the dut

module tb_id_bitmap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import ida_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 250;
    localparam int FILL_FREE   = 760;
    localparam int MIXED_WORDS = 230;
    localparam int DRAIN_WORDS = 60;
    localparam int NDIR        = 24;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        id_t  id;
        logic status;
    } grant_t;

    typedef struct packed {
        logic act;
        id_t  id;
        logic typed;
        id_t  t_id;
        logic t_status;
    } dir_row_t;

    typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic action;
    id_t  id_in;
    logic out_valid;
    logic out_ready;
    id_t  id_out;
    logic status;

    // shadow copy of the used-id bitmap
    word_t  used_map [NWORDS];
    id_t    last_freed;
    int     free_ids;
    grant_t pending_grants [$];

    int words_taken = 0;
    int errors      = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    bit hold_done   = 1'b0;

    // rows with a typed result are read straight off the behavior after reset
    dir_row_t dir_rows [NDIR] = '{
        '{ACT_ALLOC,   10'd0,    1'b1, 10'd1,    STATUS_OK},
        '{ACT_ALLOC,   10'd1023, 1'b1, 10'd2,    STATUS_OK},
        '{ACT_RELEASE, 10'd0,    1'b1, 10'd0,    STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b1, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd1023, 1'b1, 10'd1023, STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b1, 10'd3,    STATUS_OK},
        '{ACT_RELEASE, 10'd5,    1'b1, 10'd5,    STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b0, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd512,  1'b1, 10'd512,  STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b0, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd2,    1'b1, 10'd2,    STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b0, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd1022, 1'b1, 10'd1022, STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b0, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd31,   1'b1, 10'd31,   STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b0, 10'd0,    STATUS_OK},
        '{ACT_ALLOC,   10'd682,  1'b0, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd0,    1'b1, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd0,    1'b1, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd682,  1'b1, 10'd682,  STATUS_OK},
        '{ACT_RELEASE, 10'd341,  1'b1, 10'd341,  STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b0, 10'd0,    STATUS_OK},
        '{ACT_RELEASE, 10'd1023, 1'b1, 10'd1023, STATUS_OK},
        '{ACT_ALLOC,   10'd0,    1'b0, 10'd0,    STATUS_OK}
    };

    id_bitmap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .id_in     (id_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .id_out    (id_out),
        .status    (status)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        errors++;
    endtask

    // next-fit grant scans circularly from the word of last freed id + 1; releases clear ids
    task automatic grant_or_free(input logic act, input id_t id, output grant_t g);
        int start_id;
        int w;
        int b;
        int n;
        int k;
        g.id     = id;
        g.status = STATUS_OK;
        if (act == ACT_RELEASE)
        begin
            if (int'(id) < NUM_IDS)
            begin
                w = int'(id) / WORD_BITS;
                b = int'(id) % WORD_BITS;
                if (used_map[w][b])
                begin
                    free_ids++;
                end
                used_map[w][b] = 1'b0;
                last_freed     = id;
            end
        end
        else
        begin
            g.id     = '0;
            g.status = STATUS_FAIL;
            start_id = int'(last_freed) + 1;
            if (start_id >= NUM_IDS)
            begin
                start_id = 0;
            end
            w = start_id / WORD_BITS;
            for (n = 0; n < NWORDS && g.status == STATUS_FAIL; n++)
            begin
                if (used_map[w] != '1)
                begin
                    // lowest clear bit, not necessarily at or above the start id
                    b = WORD_BITS;
                    for (k = WORD_BITS - 1; k >= 0; k--)
                    begin
                        if (!used_map[w][k])
                        begin
                            b = k;
                        end
                    end
                    used_map[w][b] = 1'b1;
                    free_ids--;
                    g.id     = id_t'(w * WORD_BITS + b);
                    g.status = STATUS_OK;
                end
                w = (w + 1) % NWORDS;
            end
        end
    endtask

    function automatic id_t pick_busy_id();
        id_t cand;
        int  tries;
        cand = id_t'($urandom);
        for (tries = 0; tries < 200 && !used_map[cand[ID_W-1:BIT_W]][cand[BIT_W-1:0]];
             tries++)
        begin
            cand = id_t'($urandom);
        end
        return cand;
    endfunction

    // holds the word until the handshake, sampled mid-cycle so the edge sees stable values
    task automatic send_word(input logic act, input id_t id, input logic typed,
                             input grant_t typed_g);
        grant_t g;
        int     gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action   <= act;
        id_in    <= id;
        do @(negedge clk); while (!in_ready);
        grant_or_free(act, id, g);
        pending_grants.push_back(typed ? typed_g : g);
        words_taken++;
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        grant_t exp_g;
        if (rst_n === 1'b1 && out_valid && out_ready)
        begin
            if (pending_grants.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word id=%0d status=%0d", id_out, status));
            end
            else
            begin
                exp_g = pending_grants.pop_front();
                if (id_out !== exp_g.id)
                begin
                    flag_mismatch($sformatf("id_out got %0d exp %0d", id_out, exp_g.id));
                end
                if (status !== exp_g.status)
                begin
                    flag_mismatch($sformatf("status got %0d exp %0d", status, exp_g.status));
                end
            end
        end
    end

    // receiver: random stall modes, plus one long hold-off once traffic is flowing
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            tick++;
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (!hold_done && words_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        grant_t tg;
        int     i;
        int     r;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        action   <= ACT_ALLOC;
        id_in    <= '0;
        for (i = 0; i < NWORDS; i++)
        begin
            used_map[i] = '0;
        end
        used_map[0] = word_t'(1);
        last_freed  = '0;
        free_ids    = NUM_IDS - 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NDIR; i++)
        begin
            tg.id     = dir_rows[i].t_id;
            tg.status = dir_rows[i].t_status;
            send_word(dir_rows[i].act, dir_rows[i].id, dir_rows[i].typed, tg);
        end

        // partly fill the map with allocs and a trickle of releases so scans cross full words
        while (free_ids > FILL_FREE)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(ACT_RELEASE, id_t'($urandom), 1'b0, '0);
            end
            else
            begin
                send_word(ACT_ALLOC, id_t'($urandom), 1'b0, '0);
            end
        end
        repeat (3) send_word(ACT_ALLOC, id_t'($urandom), 1'b0, '0);

        // churn on the partly filled map, then a release-heavy tail that thins it out
        for (i = 0; i < MIXED_WORDS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < ((i < MIXED_WORDS - DRAIN_WORDS) ? 55 : 25))
            begin
                send_word(ACT_ALLOC, id_t'($urandom), 1'b0, '0);
            end
            else if (r < 85)
            begin
                send_word(ACT_RELEASE, pick_busy_id(), 1'b0, '0);
            end
            else
            begin
                send_word(ACT_RELEASE, id_t'($urandom), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (pending_grants.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: id_bitmap_allocator.f
design/ida_pkg.sv
design/ida_bitmap.sv
design/ida_ffz.sv
design/id_bitmap_allocator.sv
design/ida_checker.sv
tb/sv/tb_id_bitmap_allocator.sv
